// ===== rtl/sidct_pkg.sv =====
// ----------------------------------------------------------------------------
// sidct_pkg: shared types, constants and tables of the scaled 8x8 IDCT core
// Holds the ALU op codes, the micro-op format, the micro-program of one 1-D
// pass and the scale and de-zigzag tables.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sidct_pkg;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL45,
    OP_MUL181,
    OP_SHL2,
    OP_SHL7,
    OP_SHL8,
    OP_ASR7,
    OP_ASR8
  } alu_op_e;

  // working register indexes: v0..v7, then s, d, t, u
  localparam logic [3:0] R_V0 = 4'd0;
  localparam logic [3:0] R_V1 = 4'd1;
  localparam logic [3:0] R_V2 = 4'd2;
  localparam logic [3:0] R_V3 = 4'd3;
  localparam logic [3:0] R_V4 = 4'd4;
  localparam logic [3:0] R_V5 = 4'd5;
  localparam logic [3:0] R_V6 = 4'd6;
  localparam logic [3:0] R_V7 = 4'd7;
  localparam logic [3:0] R_S  = 4'd8;
  localparam logic [3:0] R_D  = 4'd9;
  localparam logic [3:0] R_T  = 4'd10;
  localparam logic [3:0] R_U  = 4'd11;
  localparam int unsigned NumRegs = 12;

  localparam logic [5:0] UopLast = 6'd48;

  localparam logic [31:0] DcBiasFixed = 32'd16384;
  localparam logic [31:0] DcBiasQuant = 32'((1024 + 4) << 12);

  typedef struct packed {
    alu_op_e    op;
    logic [3:0] dst;
    logic [3:0] a;
    logic [3:0] b;
    logic       wr;    // result goes to the pass output store
    logic [2:0] oidx;  // output slot of the pass
  } uop_t;

  function automatic uop_t mk(alu_op_e op, logic [3:0] dst, logic [3:0] a, logic [3:0] b);
    uop_t u;
    u.op = op; u.dst = dst; u.a = a; u.b = b; u.wr = 1'b0; u.oidx = 3'd0;
    return u;
  endfunction

  function automatic uop_t mo(alu_op_e op, logic [3:0] a, logic [3:0] b, logic [2:0] k);
    uop_t u;
    u.op = op; u.dst = R_T; u.a = a; u.b = b; u.wr = 1'b1; u.oidx = k;
    return u;
  endfunction

  // micro-program of one 1-D butterfly pass
  function automatic uop_t uop_rom(logic [5:0] pc);
    uop_t u;
    case (pc)
      6'd0:  u = mk(OP_ADD,    R_S,  R_V1, R_V7);
      6'd1:  u = mk(OP_SUB,    R_D,  R_V1, R_V7);
      6'd2:  u = mk(OP_ADD,    R_V1, R_S,  R_V3);
      6'd3:  u = mk(OP_ADD,    R_V7, R_D,  R_V5);
      6'd4:  u = mk(OP_SUB,    R_V5, R_D,  R_V5);
      6'd5:  u = mk(OP_SUB,    R_V3, R_S,  R_V3);
      6'd6:  u = mk(OP_MUL45,  R_S,  R_V5, R_V5);
      6'd7:  u = mk(OP_MUL45,  R_D,  R_V3, R_V3);
      6'd8:  u = mk(OP_ADD,    R_T,  R_D,  R_S);
      6'd9:  u = mk(OP_SHL2,   R_U,  R_S,  R_S);
      6'd10: u = mk(OP_ADD,    R_T,  R_T,  R_U);
      6'd11: u = mk(OP_ADD,    R_T,  R_T,  R_V5);
      6'd12: u = mk(OP_SUB,    R_U,  R_D,  R_S);
      6'd13: u = mk(OP_SHL2,   R_S,  R_D,  R_D);
      6'd14: u = mk(OP_ADD,    R_U,  R_U,  R_S);
      6'd15: u = mk(OP_ADD,    R_U,  R_U,  R_V3);
      6'd16: u = mk(OP_ASR7,   R_V5, R_T,  R_T);
      6'd17: u = mk(OP_ASR7,   R_V3, R_U,  R_U);
      6'd18: u = mk(OP_SHL8,   R_S,  R_V1, R_V1);
      6'd19: u = mk(OP_SHL8,   R_D,  R_V7, R_V7);
      6'd20: u = mk(OP_ADD,    R_T,  R_D,  R_S);
      6'd21: u = mk(OP_SHL7,   R_U,  R_V1, R_V1);
      6'd22: u = mk(OP_ADD,    R_T,  R_T,  R_U);
      6'd23: u = mk(OP_SUB,    R_T,  R_T,  R_V1);
      6'd24: u = mk(OP_SUB,    R_U,  R_D,  R_S);
      6'd25: u = mk(OP_SHL7,   R_S,  R_V7, R_V7);
      6'd26: u = mk(OP_ADD,    R_U,  R_U,  R_S);
      6'd27: u = mk(OP_SUB,    R_U,  R_U,  R_V7);
      6'd28: u = mk(OP_ASR8,   R_V1, R_T,  R_T);
      6'd29: u = mk(OP_ASR8,   R_V7, R_U,  R_U);
      6'd30: u = mk(OP_SUB,    R_T,  R_V2, R_V6);
      6'd31: u = mk(OP_ADD,    R_V6, R_V6, R_V2);
      6'd32: u = mk(OP_MUL181, R_T,  R_T,  R_T);
      6'd33: u = mk(OP_ASR7,   R_T,  R_T,  R_T);
      6'd34: u = mk(OP_SUB,    R_V2, R_T,  R_V6);
      6'd35: u = mk(OP_ADD,    R_S,  R_V0, R_V4);
      6'd36: u = mk(OP_SUB,    R_D,  R_V0, R_V4);
      6'd37: u = mk(OP_ADD,    R_V0, R_S,  R_V6);
      6'd38: u = mk(OP_ADD,    R_V4, R_D,  R_V2);
      6'd39: u = mk(OP_SUB,    R_V2, R_D,  R_V2);
      6'd40: u = mk(OP_SUB,    R_V6, R_S,  R_V6);
      6'd41: u = mo(OP_ADD, R_V0, R_V1, 3'd0);
      6'd42: u = mo(OP_ADD, R_V4, R_V5, 3'd1);
      6'd43: u = mo(OP_ADD, R_V2, R_V3, 3'd2);
      6'd44: u = mo(OP_ADD, R_V6, R_V7, 3'd3);
      6'd45: u = mo(OP_SUB, R_V6, R_V7, 3'd4);
      6'd46: u = mo(OP_SUB, R_V2, R_V3, 3'd5);
      6'd47: u = mo(OP_SUB, R_V4, R_V5, 3'd6);
      6'd48: u = mo(OP_SUB, R_V0, R_V1, 3'd7);
      default: u = mk(OP_ADD, R_T, R_T, R_T);
    endcase
    return u;
  endfunction

  localparam logic [12:0] ScaleTab [64] = '{
    13'd4096, 13'd2276, 13'd5352, 13'd3218, 13'd4096, 13'd3218, 13'd2217, 13'd2276,
    13'd2276, 13'd1264, 13'd2973, 13'd1788, 13'd2276, 13'd1788, 13'd1232, 13'd1264,
    13'd5352, 13'd2973, 13'd6992, 13'd4205, 13'd5352, 13'd4205, 13'd2896, 13'd2973,
    13'd3218, 13'd1788, 13'd4205, 13'd2529, 13'd3218, 13'd2529, 13'd1742, 13'd1788,
    13'd4096, 13'd2276, 13'd5352, 13'd3218, 13'd4096, 13'd3218, 13'd2217, 13'd2276,
    13'd3218, 13'd1788, 13'd4205, 13'd2529, 13'd3218, 13'd2529, 13'd1742, 13'd1788,
    13'd2217, 13'd1232, 13'd2896, 13'd1742, 13'd2217, 13'd1742, 13'd1200, 13'd1232,
    13'd2276, 13'd1264, 13'd2973, 13'd1788, 13'd2276, 13'd1788, 13'd1232, 13'd1264
  };

  localparam logic [5:0] Unzig [64] = '{
    6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
    6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
    6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
    6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
    6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
    6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
    6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
    6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
  };

endpackage

// ===== rtl/scaled_llm_idct_8x8_core.sv =====
// ----------------------------------------------------------------------------
// scaled_llm_idct_8x8_core: scaled integer LLM 8x8 inverse DCT
// Coefficient load, two 1-D passes on one shared unit, clipped pixel output.
// ----------------------------------------------------------------------------
// A coefficient transfer reads the scale word, then multiplies and stores; a
// table-word transfer is written straight into the table store. On the
// coefficient that carries block_end the core runs 16 one-dimensional passes
// (8 reads from a single-port store with registered read data, then 49
// micro-ops on the one shared ALU), then sends 64 pixels in raster order,
// each held until the sink is ready. The input is not ready while a block is
// transformed or emitted. Coefficient positions not loaded in a block read as
// zero.
`timescale 1ns / 1ps

module scaled_llm_idct_8x8_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [5:0]  position_i,
  input  logic signed [15:0] coef_value_i,
  input  logic [20:0] table_value_i,
  input  logic        block_end_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  pixel_o,
  output logic [5:0]  pixel_index_o,
  output logic        last_pixel_o
);

  import sidct_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_LOAD,
    ST_EXEC,
    ST_EMIT_RD,
    ST_EMIT_CAP,
    ST_EMIT_HOLD
  } state_e;

  state_e      state_q;
  logic        mode_q;
  logic [63:0] mask_q;       // coefficient loaded in this block
  logic        pass_q;       // 0 rows, 1 columns
  logic [2:0]  line_q;
  logic [3:0]  ld_q;
  logic [5:0]  pc_q;
  logic [5:0]  emit_q;
  logic [5:0]  rd_addr_q;
  logic [5:0]  pos_q;
  logic signed [15:0] coef_q;
  logic        end_q;
  logic        out_valid_q;
  logic [7:0]  pixel_q;
  logic [5:0]  pix_idx_q;
  logic        last_q;
  logic [31:0] rf_q [NumRegs];

  logic        in_xfer;
  uop_t        uc;
  logic [31:0] alu_y;

  logic        q_we, c_we, t_we;
  logic [5:0]  c_addr, t_addr;
  logic [31:0] c_wdata;
  logic [20:0] q_rdata;
  logic [31:0] c_rdata, t_rdata;

  logic signed [37:0] prod;
  logic [31:0] prod_b;
  logic [5:0]  st_addr;
  logic [31:0] ld_data;
  logic [7:0]  clamp;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i & in_ready_o;
  assign q_we        = in_xfer & cmd_i;

  assign uc = uop_rom(pc_q);

  sidct_alu u_alu (
    .op_i (uc.op),
    .a_i  (rf_q[uc.a]),
    .b_i  (rf_q[uc.b]),
    .y_o  (alu_y)
  );

  // scaled coefficient: fixed scale in mode 0, loaded table word in mode 1
  always_comb begin
    prod = 38'(coef_q) * $signed({17'd0, mode_q ? q_rdata : {8'd0, ScaleTab[pos_q]}});
    prod_b = prod[31:0];
    if (pos_q == 6'd0) begin
      prod_b = prod_b + (mode_q ? DcBiasQuant : DcBiasFixed);
    end
    st_addr = mode_q ? Unzig[pos_q] : pos_q;
  end

  // store port steering
  always_comb begin
    c_we    = 1'b0;
    c_addr  = {line_q, ld_q[2:0]};
    c_wdata = alu_y;
    t_we    = 1'b0;
    t_addr  = {line_q, ld_q[2:0]};
    case (state_q)
      ST_MUL: begin
        c_we    = 1'b1;
        c_addr  = st_addr;
        c_wdata = prod_b;
      end
      ST_EXEC: begin
        c_addr = {uc.oidx, line_q};
        t_addr = {uc.oidx, line_q};
        c_we   = uc.wr & pass_q;
        t_we   = uc.wr & ~pass_q;
      end
      ST_EMIT_RD: c_addr = emit_q;
      default: ;
    endcase
  end

  sidct_ram #(.Width(21), .Depth(64)) u_qtab (
    .clk_i, .we_i(q_we), .addr_i(position_i), .wdata_i(table_value_i), .rdata_o(q_rdata)
  );

  sidct_ram #(.Width(32), .Depth(64)) u_coef (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wdata), .rdata_o(c_rdata)
  );

  sidct_ram #(.Width(32), .Depth(64)) u_trans (
    .clk_i, .we_i(t_we), .addr_i(t_addr), .wdata_i(alu_y), .rdata_o(t_rdata)
  );

  // row pass sees unloaded positions as zero
  assign ld_data = pass_q ? t_rdata : (mask_q[rd_addr_q] ? c_rdata : 32'd0);

  // shift right by 15 then clamp to 0..255
  always_comb begin
    if (c_rdata[31])             clamp = 8'd0;
    else if (|c_rdata[30:23])    clamp = 8'd255;
    else                         clamp = c_rdata[22:15];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      mode_q      <= 1'b0;
      mask_q      <= '0;
      pass_q      <= 1'b0;
      line_q      <= '0;
      ld_q        <= '0;
      pc_q        <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        mode_q <= cfg_data_i;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_xfer && !cmd_i) begin
            pos_q   <= position_i;
            coef_q  <= coef_value_i;
            end_q   <= block_end_i;
            state_q <= ST_MUL;
          end
        end
        ST_MUL: begin
          mask_q[st_addr] <= 1'b1;
          pass_q <= 1'b0;
          line_q <= '0;
          ld_q   <= '0;
          state_q <= end_q ? ST_LOAD : ST_IDLE;
        end
        ST_LOAD: begin
          rd_addr_q <= {line_q, ld_q[2:0]};
          if (ld_q != 4'd0) begin
            rf_q[3'(ld_q - 4'd1)] <= ld_data;
          end
          if (ld_q == 4'd8) begin
            pc_q    <= '0;
            state_q <= ST_EXEC;
          end else begin
            ld_q <= ld_q + 4'd1;
          end
        end
        ST_EXEC: begin
          if (!uc.wr) begin
            rf_q[uc.dst] <= alu_y;
          end
          if (pc_q == UopLast) begin
            ld_q <= '0;
            if (line_q == 3'd7) begin
              line_q <= '0;
              if (pass_q) begin
                emit_q  <= '0;
                state_q <= ST_EMIT_RD;
              end else begin
                pass_q  <= 1'b1;
                state_q <= ST_LOAD;
              end
            end else begin
              line_q  <= line_q + 3'd1;
              state_q <= ST_LOAD;
            end
          end else begin
            pc_q <= pc_q + 6'd1;
          end
        end
        ST_EMIT_RD: state_q <= ST_EMIT_CAP;
        ST_EMIT_CAP: begin
          pixel_q     <= clamp;
          pix_idx_q   <= emit_q;
          last_q      <= (emit_q == 6'd63);
          out_valid_q <= 1'b1;
          state_q     <= ST_EMIT_HOLD;
        end
        ST_EMIT_HOLD: begin
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
            if (last_q) begin
              mask_q  <= '0;
              state_q <= ST_IDLE;
            end else begin
              emit_q  <= emit_q + 6'd1;
              state_q <= ST_EMIT_RD;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_o       = pixel_q;
  assign pixel_index_o = pix_idx_q;
  assign last_pixel_o  = last_q;

  // no input transfer while a pixel waits
  a_no_in_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !in_ready_o) else $error("input ready while pixel pending");

  // last pixel flag only on raster position 63
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && last_q) |-> (pix_idx_q == 6'd63)) else $error("bad last pixel");

  // output transfers follow the raster counter
  a_idx_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (pix_idx_q == emit_q)) else $error("pixel index mismatch");

  // the coefficient and transpose stores are never written together
  a_one_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(t_we && c_we)) else $error("both stores written");

endmodule

// ===== rtl/sidct_ram.sv =====
// ----------------------------------------------------------------------------
// sidct_ram: generic single-port RAM
// One address for read or write per cycle, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sidct_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/sidct_alu.sv =====
// ----------------------------------------------------------------------------
// sidct_alu: shared butterfly unit
// Add, subtract, constant multiply by 45 or 181 and fixed shifts, modulo 2^32.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sidct_alu (
  input  sidct_pkg::alu_op_e op_i,
  input  logic [31:0]        a_i,
  input  logic [31:0]        b_i,
  output logic [31:0]        y_o
);

  import sidct_pkg::*;

  always_comb begin
    case (op_i)
      OP_ADD:    y_o = a_i + b_i;
      OP_SUB:    y_o = a_i - b_i;
      OP_MUL45:  y_o = a_i * 32'd45;
      OP_MUL181: y_o = a_i * 32'd181;
      OP_SHL2:   y_o = a_i << 2;
      OP_SHL7:   y_o = a_i << 7;
      OP_SHL8:   y_o = a_i << 8;
      OP_ASR7:   y_o = 32'($signed(a_i) >>> 7);
      OP_ASR8:   y_o = 32'($signed(a_i) >>> 8);
      default:   y_o = a_i;
    endcase
  end

endmodule
